// ----- hdl/nsf_pkg.sv -----
// Shared types, character codes and status/kind codes for the NMEA sentence framer.
// No dependencies; used by every module under hdl/.
package nsf_pkg;

  localparam int BYTE_W = 8;
  localparam int COUNT_W = 8;
  localparam int PHASE_W = 3;
  localparam int TAG_CHARS = 5;
  localparam int TAG_W = TAG_CHARS * BYTE_W;
  localparam int TAG_LEN_W = 3;

  // Characters of the sentence grammar
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_MIN = 8'd32;
  localparam logic [BYTE_W-1:0] CH_MAX = 8'd127;
  localparam logic [BYTE_W-1:0] CH_0 = 8'h30;
  localparam logic [BYTE_W-1:0] CH_A = 8'h41;
  localparam logic [BYTE_W-1:0] CH_P = 8'h50;
  localparam logic [BYTE_W-1:0] CH_O = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_H = 8'h48;
  localparam logic [BYTE_W-1:0] CH_R = 8'h52;
  localparam logic [BYTE_W-1:0] CH_G = 8'h47;
  localparam logic [BYTE_W-1:0] CH_M = 8'h4D;
  localparam logic [BYTE_W-1:0] CH_C = 8'h43;

  // Parse phases
  localparam logic [PHASE_W-1:0] PH_BODY = 3'd0;
  localparam logic [PHASE_W-1:0] PH_HEX1 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HEX2 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_CR = 3'd3;
  localparam logic [PHASE_W-1:0] PH_TAIL = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_BAD_CHAR = 2'd1;
  localparam logic [1:0] ST_BAD_SUM = 2'd2;
  localparam logic [1:0] ST_NO_CR = 2'd3;

  // Sentence kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_GGA = 2'd1;
  localparam logic [1:0] KIND_RMC = 2'd2;
  localparam logic [1:0] KIND_POHPR = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] sentence_kind;
    logic [COUNT_W-1:0] field_count;
    logic [BYTE_W-1:0] checksum;
  } res_t;

  // Uppercase hex character for one nibble
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] ext;
    ext = {4'b0000, nib};
    if (nib < 4'd10) return CH_0 + ext;
    return CH_A + ext - 8'd10;
  endfunction

  // Sentence kind from the first five tag characters
  function automatic logic [1:0] classify(input logic [TAG_W-1:0] tag,
                                          input logic [TAG_LEN_W-1:0] len);
    if (len != 3'd5) return KIND_UNKNOWN;
    if (tag[7:0] == CH_P && tag[15:8] == CH_O && tag[23:16] == CH_H &&
        tag[31:24] == CH_P && tag[39:32] == CH_R) return KIND_POHPR;
    if (tag[23:16] == CH_G && tag[31:24] == CH_G && tag[39:32] == CH_A) return KIND_GGA;
    if (tag[23:16] == CH_R && tag[31:24] == CH_M && tag[39:32] == CH_C) return KIND_RMC;
    return KIND_UNKNOWN;
  endfunction

endpackage

// ----- hdl/nsf_in_reg.sv -----
// Input register of the NMEA sentence framer: holds one received byte.
// Depends on nsf_pkg.
module nsf_in_reg (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [nsf_pkg::BYTE_W-1:0] rx_byte,
  input  logic advance,
  output logic in_stall,
  output logic q_valid,
  output logic [nsf_pkg::BYTE_W-1:0] q_byte
);

  logic accept;

  assign in_stall = q_valid & ~advance;
  assign accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (accept) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_byte <= rx_byte;
    end
  end

endmodule

// ----- hdl/nsf_frame.sv -----
// Framing state of the NMEA sentence framer: checks one byte per step and
// builds the result on LF. Depends on nsf_pkg.
module nsf_frame #(
  parameter int MAX_SENTENCE = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic [nsf_pkg::BYTE_W-1:0] b,
  output logic res_fire,
  output nsf_pkg::res_t res
);

  logic in_frame, in_frame_next;
  logic [nsf_pkg::COUNT_W-1:0] byte_count, byte_count_next;
  logic [nsf_pkg::PHASE_W-1:0] phase, phase_next;
  logic [nsf_pkg::BYTE_W-1:0] running_xor, running_xor_next;
  logic [1:0] first_error, first_error_next;
  logic [nsf_pkg::COUNT_W-1:0] comma_count, comma_count_next;
  logic [nsf_pkg::TAG_W-1:0] tag_chars, tag_chars_next;
  logic [nsf_pkg::TAG_LEN_W-1:0] tag_length, tag_length_next;
  logic tag_closed, tag_closed_next;

  always_comb begin
    in_frame_next = in_frame;
    byte_count_next = byte_count;
    phase_next = phase;
    running_xor_next = running_xor;
    first_error_next = first_error;
    comma_count_next = comma_count;
    tag_chars_next = tag_chars;
    tag_length_next = tag_length;
    tag_closed_next = tag_closed;
    res_fire = 1'b0;

    if (step) begin
      if (b == nsf_pkg::CH_DOLLAR) begin
        // restart the sentence
        in_frame_next = 1'b1;
        byte_count_next = 8'd1;
        phase_next = nsf_pkg::PH_BODY;
        running_xor_next = '0;
        first_error_next = nsf_pkg::ST_OK;
        comma_count_next = '0;
        tag_chars_next = '0;
        tag_length_next = '0;
        tag_closed_next = 1'b0;
      end else if (in_frame) begin
        if (byte_count >= 8'(MAX_SENTENCE)) begin
          in_frame_next = 1'b0;  // drop overlong sentence
        end else begin
          byte_count_next = byte_count + 8'd1;
          if (first_error == nsf_pkg::ST_OK) begin
            case (phase)
              nsf_pkg::PH_BODY: begin
                if (b == nsf_pkg::CH_STAR) begin
                  tag_closed_next = 1'b1;
                  phase_next = nsf_pkg::PH_HEX1;
                end else if (!(b inside {[nsf_pkg::CH_MIN:nsf_pkg::CH_MAX]})) begin
                  first_error_next = nsf_pkg::ST_BAD_CHAR;
                end else begin
                  running_xor_next = running_xor ^ b;
                  if (b == nsf_pkg::CH_COMMA) begin
                    if (comma_count != 8'hFF) comma_count_next = comma_count + 8'd1;
                    tag_closed_next = 1'b1;
                  end else if (!tag_closed) begin
                    if (tag_length < 3'd5) tag_chars_next[{tag_length, 3'b000} +: 8] = b;
                    if (tag_length != 3'd7) tag_length_next = tag_length + 3'd1;
                  end
                end
              end
              nsf_pkg::PH_HEX1: begin
                if (b != nsf_pkg::hex_char(running_xor[7:4]))
                  first_error_next = nsf_pkg::ST_BAD_SUM;
                else
                  phase_next = nsf_pkg::PH_HEX2;
              end
              nsf_pkg::PH_HEX2: begin
                if (b != nsf_pkg::hex_char(running_xor[3:0]))
                  first_error_next = nsf_pkg::ST_BAD_SUM;
                else
                  phase_next = nsf_pkg::PH_CR;
              end
              nsf_pkg::PH_CR: begin
                if (b != nsf_pkg::CH_CR)
                  first_error_next = nsf_pkg::ST_NO_CR;
                else
                  phase_next = nsf_pkg::PH_TAIL;
              end
              default: begin
              end
            endcase
          end
          if (b == nsf_pkg::CH_LF) begin
            in_frame_next = 1'b0;
            res_fire = 1'b1;
          end
        end
      end
    end

    res.status = first_error_next;
    res.sentence_kind = (first_error_next == nsf_pkg::ST_OK) ?
                        nsf_pkg::classify(tag_chars_next, tag_length_next) :
                        nsf_pkg::KIND_UNKNOWN;
    res.field_count = comma_count_next;
    res.checksum = running_xor_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame <= 1'b0;
      byte_count <= '0;
      phase <= nsf_pkg::PH_BODY;
      running_xor <= '0;
      first_error <= nsf_pkg::ST_OK;
      comma_count <= '0;
      tag_chars <= '0;
      tag_length <= '0;
      tag_closed <= 1'b0;
    end else begin
      in_frame <= in_frame_next;
      byte_count <= byte_count_next;
      phase <= phase_next;
      running_xor <= running_xor_next;
      first_error <= first_error_next;
      comma_count <= comma_count_next;
      tag_chars <= tag_chars_next;
      tag_length <= tag_length_next;
      tag_closed <= tag_closed_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_kind_only_ok: assert property (@(posedge clk) disable iff (rst)
    res_fire && res.sentence_kind != nsf_pkg::KIND_UNKNOWN |-> res.status == nsf_pkg::ST_OK)
    else $error("sentence kind reported with error status");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= 8'(MAX_SENTENCE))
    else $error("byte count passed sentence limit");

  a_dollar_restart: assert property (@(posedge clk) disable iff (rst)
    step && b == nsf_pkg::CH_DOLLAR |=> in_frame && byte_count == 8'd1 &&
    first_error == nsf_pkg::ST_OK)
    else $error("dollar did not restart the frame");

  a_lf_closes: assert property (@(posedge clk) disable iff (rst)
    res_fire |=> !in_frame)
    else $error("frame still open after result");
`endif

endmodule

// ----- hdl/nsf_out_reg.sv -----
// Result register of the NMEA sentence framer: holds one result beat.
// Depends on nsf_pkg.
module nsf_out_reg (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  nsf_pkg::res_t res,
  input  logic out_stall,
  output logic out_free,
  output logic out_valid,
  output nsf_pkg::res_t out_res
);

  assign out_free = ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule

// ----- hdl/nmea_sentence_framer.sv -----
// Path: an accepted byte is held in the input register; a closing LF loads its result into the result register.
// Throughput: one byte per cycle; the input register and framing logic advance
// whenever the result register is empty or being drained.
// Reset (rst, synchronous, active high): no frame open, waiting for '$';
// input and result registers empty. No clearing pass is needed.
// Depends on nsf_pkg, nsf_in_reg, nsf_frame, nsf_out_reg.
module nmea_sentence_framer #(
  parameter int MAX_SENTENCE = 128
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [7:0] rx_byte,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [1:0] sentence_kind,
  output logic [7:0] field_count,
  output logic [7:0] checksum
);

  logic q_valid;
  logic [nsf_pkg::BYTE_W-1:0] q_byte;
  logic advance;
  logic out_free;
  logic res_fire;
  nsf_pkg::res_t res;
  nsf_pkg::res_t out_res;

  // Advance the held byte whenever the result register can take a beat,
  // whether or not this byte produces one.
  assign advance = q_valid & out_free;

  nsf_in_reg u_in (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .rx_byte(rx_byte),
    .advance(advance),
    .in_stall(in_stall),
    .q_valid(q_valid),
    .q_byte(q_byte)
  );

  // Framing state: one step per advanced byte; fires on the closing LF.
  nsf_frame #(
    .MAX_SENTENCE(MAX_SENTENCE)
  ) u_frame (
    .clk(clk),
    .rst(rst),
    .step(advance),
    .b(q_byte),
    .res_fire(res_fire),
    .res(res)
  );

  // Hold the result beat until the consumer takes it.
  nsf_out_reg u_out (
    .clk(clk),
    .rst(rst),
    .load(res_fire),
    .res(res),
    .out_stall(out_stall),
    .out_free(out_free),
    .out_valid(out_valid),
    .out_res(out_res)
  );

  assign status = out_res.status;
  assign sentence_kind = out_res.sentence_kind;
  assign field_count = out_res.field_count;
  assign checksum = out_res.checksum;

endmodule

// ----- bench/testbench.sv -----
// Self-checking bench for nmea_sentence_framer: a table of directed sentences, then random traffic.
// Depends on nsf_pkg and the framer RTL; it carries its own byte-level model of the framer.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_SENTENCE   = 128;
  localparam int WATCHDOG_LIMIT = 200;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES   = 10;
  localparam int RANDOM_BEATS   = 40;

  // Markers inside table text: a NUL cannot live in a string, and the two
  // checksum digits are only known once the body has been sent.
  localparam logic [7:0] NUL_MARK = 8'h01;
  localparam logic [7:0] SUM_MARK = 8'h3F;  // '?'

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] status;
  logic [1:0] sentence_kind;
  logic [7:0] field_count;
  logic [7:0] checksum;

  nmea_sentence_framer #(.MAX_SENTENCE(MAX_SENTENCE)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .sentence_kind(sentence_kind),
    .field_count  (field_count),
    .checksum     (checksum)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Framer model: one call per accepted rx beat. It keeps its own copy of the
  // frame state and hands back a sentence report whenever a LF closes a frame.
  // ---------------------------------------------------------------------------
  logic       frm_open;
  logic [7:0] frm_bytes;     // bytes stored in this frame, the '$' included
  logic [2:0] frm_phase;
  logic [7:0] frm_xor;
  logic [1:0] frm_err;       // first error wins; later bytes go unchecked
  logic [7:0] frm_commas;
  logic [7:0] frm_tag [nsf_pkg::TAG_CHARS];
  logic [2:0] frm_tag_len;   // saturates at 7 so long tags never look like 5
  logic       frm_tag_done;

  nsf_pkg::res_t report_q [$];  // sentence reports still owed by the block
  int   rx_beats = 0;
  int   fault_count = 0;
  bit   calm = 1'b1;         // no idling on either side while set

  task automatic clear_frame();
    frm_bytes    = '0;
    frm_phase    = nsf_pkg::PH_BODY;
    frm_xor      = '0;
    frm_err      = nsf_pkg::ST_OK;
    frm_commas   = '0;
    frm_tag_len  = '0;
    frm_tag_done = 1'b0;
    foreach (frm_tag[i]) frm_tag[i] = '0;
  endtask

  function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
    return (nib < 4'd10) ? nsf_pkg::CH_0 + {4'h0, nib} :
                           nsf_pkg::CH_A + {4'h0, nib} - 8'd10;
  endfunction

  // Kind comes from the first five tag chars, and only an exact length of 5 counts.
  function automatic logic [1:0] tag_kind();
    if (frm_tag_len != 3'd5) return nsf_pkg::KIND_UNKNOWN;
    if ({frm_tag[0], frm_tag[1], frm_tag[2], frm_tag[3], frm_tag[4]} ==
        {nsf_pkg::CH_P, nsf_pkg::CH_O, nsf_pkg::CH_H, nsf_pkg::CH_P, nsf_pkg::CH_R})
      return nsf_pkg::KIND_POHPR;
    if ({frm_tag[2], frm_tag[3], frm_tag[4]} ==
        {nsf_pkg::CH_G, nsf_pkg::CH_G, nsf_pkg::CH_A}) return nsf_pkg::KIND_GGA;
    if ({frm_tag[2], frm_tag[3], frm_tag[4]} ==
        {nsf_pkg::CH_R, nsf_pkg::CH_M, nsf_pkg::CH_C}) return nsf_pkg::KIND_RMC;
    return nsf_pkg::KIND_UNKNOWN;
  endfunction

  task automatic advance_framer(input logic [7:0] b, output bit got,
                                output nsf_pkg::res_t rep);
    got = 1'b0;
    rep = '0;
    // any '$' restarts, even mid-sentence or inside a dropped one
    if (b == nsf_pkg::CH_DOLLAR) begin
      clear_frame();
      frm_open  = 1'b1;
      frm_bytes = 8'd1;
      return;
    end
    if (!frm_open) return;
    // overlong: drop the frame silently and wait for the next '$'
    if (frm_bytes >= MAX_SENTENCE) begin
      frm_open = 1'b0;
      return;
    end
    frm_bytes++;
    if (frm_err == nsf_pkg::ST_OK) begin
      case (frm_phase)
        nsf_pkg::PH_BODY: begin
          if (b == nsf_pkg::CH_STAR) begin
            frm_tag_done = 1'b1;
            frm_phase    = nsf_pkg::PH_HEX1;
          end else if (b < nsf_pkg::CH_MIN || b > nsf_pkg::CH_MAX) begin
            frm_err = nsf_pkg::ST_BAD_CHAR;  // a LF before the star lands here too
          end else begin
            frm_xor ^= b;
            if (b == nsf_pkg::CH_COMMA) begin
              if (frm_commas != 8'hFF) frm_commas++;
              frm_tag_done = 1'b1;
            end else if (!frm_tag_done) begin
              if (frm_tag_len < 3'd5) frm_tag[frm_tag_len] = b;
              if (frm_tag_len != 3'd7) frm_tag_len++;
            end
          end
        end
        // only uppercase digits match; lowercase counts as a mismatch
        nsf_pkg::PH_HEX1: if (b != hex_ascii(frm_xor[7:4])) frm_err = nsf_pkg::ST_BAD_SUM;
                          else frm_phase = nsf_pkg::PH_HEX2;
        nsf_pkg::PH_HEX2: if (b != hex_ascii(frm_xor[3:0])) frm_err = nsf_pkg::ST_BAD_SUM;
                          else frm_phase = nsf_pkg::PH_CR;
        nsf_pkg::PH_CR:   if (b != nsf_pkg::CH_CR) frm_err = nsf_pkg::ST_NO_CR;
                          else frm_phase = nsf_pkg::PH_TAIL;
        default: ;  // tail after CR: ignore everything up to the LF
      endcase
    end
    if (b != nsf_pkg::CH_LF) return;
    frm_open = 1'b0;
    got = 1'b1;
    rep.status        = frm_err;
    rep.sentence_kind = (frm_err == nsf_pkg::ST_OK) ? tag_kind() : nsf_pkg::KIND_UNKNOWN;
    rep.field_count   = frm_commas;
    rep.checksum      = frm_xor;
  endtask

  // ---------------------------------------------------------------------------
  // rx side. Drive at the falling edge, look for the handshake at the rising
  // edge. A typed row supplies its own report for its closing LF instead of
  // the model's.
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input bit typed_yields = 1'b0,
                           input nsf_pkg::res_t typed_want = '0);
    bit            got;
    nsf_pkg::res_t rep;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_stall);
    rx_beats++;
    advance_framer(b, got, rep);
    if (typed ? (b == nsf_pkg::CH_LF && typed_yields) : got)
      report_q.push_back(typed ? typed_want : rep);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit typed = 1'b0,
                           input bit typed_yields = 1'b0,
                           input nsf_pkg::res_t typed_want = '0);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c == NUL_MARK) c = 8'h00;
      else if (c == SUM_MARK)
        c = hex_ascii(frm_phase == nsf_pkg::PH_HEX1 ? frm_xor[7:4] : frm_xor[3:0]);
      send_byte(c, typed, typed_yields, typed_want);
    end
  endtask

  // Printable body char, never '$' or '*'; commas come often so fields pile up.
  function automatic logic [7:0] body_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return nsf_pkg::CH_COMMA;
    c = 8'($urandom_range(32, 127));
    if (c == nsf_pkg::CH_DOLLAR || c == nsf_pkg::CH_STAR) c = nsf_pkg::CH_COMMA;
    return c;
  endfunction

  // Mostly well-formed sentences with random content; some are broken on purpose.
  typedef enum int {
    SHAPE_GOOD, SHAPE_TAIL, SHAPE_WRONG_HI, SHAPE_LOWER_LO, SHAPE_BAD_CHAR,
    SHAPE_RESTART, SHAPE_EARLY_LF, SHAPE_NO_CR, SHAPE_OVERLONG, SHAPE_NOISE
  } shape_t;

  task automatic send_random_sentence();
    shape_t     shape;
    int         pick;
    int         nbody;
    logic [7:0] c;
    pick = $urandom_range(0, 19);
    case (pick)
      10: shape = SHAPE_TAIL;
      11: shape = SHAPE_WRONG_HI;
      12: shape = SHAPE_LOWER_LO;
      13: shape = SHAPE_BAD_CHAR;
      14: shape = SHAPE_RESTART;
      15: shape = SHAPE_EARLY_LF;
      16: shape = SHAPE_NO_CR;
      17: shape = SHAPE_OVERLONG;
      18, 19: shape = SHAPE_NOISE;
      default: shape = SHAPE_GOOD;
    endcase

    // raw bytes over the full range; a stray '$' or LF in here is fair game
    if (shape == SHAPE_NOISE) begin
      repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
      return;
    end

    send_byte(nsf_pkg::CH_DOLLAR);
    case ($urandom_range(0, 5))
      0: send_text("GPGGA");
      1: send_text("GNRMC");
      2: send_text("POHPR");
      3: send_text("INGGA");
      default: repeat ($urandom_range(0, 7))
        send_byte(8'($urandom_range(nsf_pkg::CH_A, nsf_pkg::CH_A + 8'd25)));
    endcase
    if ($urandom_range(0, 3) != 0) send_byte(nsf_pkg::CH_COMMA);

    // overlong bodies straddle the size limit
    nbody = (shape == SHAPE_OVERLONG) ? $urandom_range(110, 135) : $urandom_range(0, 16);
    for (int i = 0; i < nbody; i++) begin
      if (i == nbody / 2 && shape == SHAPE_BAD_CHAR) begin
        c = 8'($urandom_range(0, 159));  // 0..31 or, shifted up, 128..255
        if (c >= 8'd32) c = c + 8'd96;
        send_byte(c);
      end
      if (i == nbody / 2 && shape == SHAPE_RESTART) send_byte(nsf_pkg::CH_DOLLAR);
      send_byte(body_char());
    end
    if (shape == SHAPE_EARLY_LF) begin
      send_byte(nsf_pkg::CH_LF);
      return;
    end

    send_byte(nsf_pkg::CH_STAR);
    c = hex_ascii(frm_xor[7:4]);
    if (shape == SHAPE_WRONG_HI) c = hex_ascii(4'($urandom_range(0, 15)));
    send_byte(c);
    c = hex_ascii(frm_xor[3:0]);
    if (shape == SHAPE_LOWER_LO) c = c | 8'h20;  // letters go lowercase, digits stay
    send_byte(c);
    send_byte(shape == SHAPE_NO_CR ? body_char() : nsf_pkg::CH_CR);
    if (shape == SHAPE_TAIL) begin
      repeat ($urandom_range(1, 4)) begin
        c = 8'($urandom_range(0, 255));
        if (c == nsf_pkg::CH_DOLLAR || c == nsf_pkg::CH_LF) c = nsf_pkg::CH_A;
        send_byte(c);
      end
    end
    send_byte(nsf_pkg::CH_LF);
  endtask

  // ---------------------------------------------------------------------------
  // Directed sentences. Rows marked typed carry a report that can be read off
  // directly; the rest go through the model. '?' stands for a correct
  // checksum digit and \001 for a NUL byte.
  // ---------------------------------------------------------------------------
  typedef struct {
    string         text;
    bit            typed;
    bit            yields;
    nsf_pkg::res_t want;
  } sentence_row_t;

  localparam int ROWS = 21;
  sentence_row_t sentence_rows [ROWS] = '{
    // a LF with no frame open (nothing comes out), then the extremes
    '{"\001AZ\377\012",     1'b1, 1'b0,
      '{nsf_pkg::ST_OK,       nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h00}},
    '{"$\012",              1'b1, 1'b1,
      '{nsf_pkg::ST_BAD_CHAR, nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h00}},
    '{"$*00\015\012",       1'b1, 1'b1,
      '{nsf_pkg::ST_OK,       nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h00}},
    '{"$,,*00\015\012",     1'b1, 1'b1,
      '{nsf_pkg::ST_OK,       nsf_pkg::KIND_UNKNOWN, 8'd2, 8'h00}},
    '{"$ *20\015\012",      1'b1, 1'b1,
      '{nsf_pkg::ST_OK,       nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h20}},
    '{"$\177*7F\015\012",   1'b1, 1'b1,
      '{nsf_pkg::ST_OK,       nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h7F}},
    // bad body chars freeze the count and the sum where they stand; then checksum, CR and tail cases
    '{"$A\001,\012",        1'b1, 1'b1,
      '{nsf_pkg::ST_BAD_CHAR, nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h41}},
    '{"$A\200\377\012",     1'b1, 1'b1,
      '{nsf_pkg::ST_BAD_CHAR, nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h41}},
    '{"$A\037,\012",        1'b1, 1'b1,
      '{nsf_pkg::ST_BAD_CHAR, nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h41}},
    '{"$*0G\015\012",       1'b1, 1'b1,
      '{nsf_pkg::ST_BAD_SUM,  nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h00}},
    '{"$J*4a\015\012",      1'b1, 1'b1,
      '{nsf_pkg::ST_BAD_SUM,  nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h4A}},
    '{"$*00X\012",          1'b1, 1'b1,
      '{nsf_pkg::ST_NO_CR,    nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h00}},
    '{"$*00\015XY\012",     1'b1, 1'b1,
      '{nsf_pkg::ST_OK,       nsf_pkg::KIND_UNKNOWN, 8'd0, 8'h00}},
    // sentence kinds and restarts
    '{"$GPGGA,1,2*??\015\012",   1'b0, 1'b0, '0},
    '{"$GNRMC,A*??\015\012",     1'b0, 1'b0, '0},
    '{"$POHPR,*??\015\012",      1'b0, 1'b0, '0},
    '{"$POHPX*??\015\012",       1'b0, 1'b0, '0},
    '{"$GPGGAX,*??\015\012",     1'b0, 1'b0, '0},
    '{"$GGA*??\015\012",         1'b0, 1'b0, '0},
    '{"$AB$GPRMC,*??\015\012",   1'b0, 1'b0, '0},
    '{"$POHPR*00\015\012\012",   1'b0, 1'b0, '0}
  };

  // out side: random stall bursts unless calm
  int stall_left = 0;
  always @(negedge clk) begin
    if (calm) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted report with the oldest one owed.
  always @(posedge clk) begin : report_check
    nsf_pkg::res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (report_q.size() == 0) begin
        $error("unexpected report: status %0d kind %0d fields %0d sum %0h",
               status, sentence_kind, field_count, checksum);
        fault_count++;
      end else begin
        want = report_q.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fault_count++;
        end
        if (sentence_kind !== want.sentence_kind) begin
          $error("sentence_kind: expected %0d, got %0d", want.sentence_kind, sentence_kind);
          fault_count++;
        end
        if (field_count !== want.field_count) begin
          $error("field_count: expected %0d, got %0d", want.field_count, field_count);
          fault_count++;
        end
        if (checksum !== want.checksum) begin
          $error("checksum: expected %0h, got %0h", want.checksum, checksum);
          fault_count++;
        end
      end
    end
  end

  // Watchdog: give up once neither side has moved a beat for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    string long_line;
    frm_open = 1'b0;
    clear_frame();

    // hold reset, then release it on a falling edge
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed rows, then the size limit: the first sentence just fits,
    // the second is one byte too long and is dropped
    calm = 1'b0;
    foreach (sentence_rows[i])
      send_text(sentence_rows[i].text, sentence_rows[i].typed,
                sentence_rows[i].yields, sentence_rows[i].want);
    for (int n = MAX_SENTENCE - 6; n <= MAX_SENTENCE - 5; n++) begin
      long_line = "$";
      repeat (n) long_line = {long_line, "A"};
      send_text({long_line, "*??\015\012"});
    end

    // random traffic; about one sentence in five runs with no idling at all
    rx_beats = 0;
    while (rx_beats < RANDOM_BEATS) begin
      calm = ($urandom_range(0, 4) == 0);
      send_random_sentence();
    end

    // final stretch at full rate on both sides
    calm = 1'b1;
    repeat (3) send_random_sentence();

    in_valid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/nsf_pkg.sv
hdl/nsf_in_reg.sv
hdl/nsf_frame.sv
hdl/nsf_out_reg.sv
hdl/nmea_sentence_framer.sv
bench/testbench.sv
